// ===== design/retro_pad_to_classic_mapper_assert.svh =====
// Assertion macros shared by the mapper RTL.
`ifndef RETRO_PAD_TO_CLASSIC_MAPPER_ASSERT_SVH
`define RETRO_PAD_TO_CLASSIC_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RPCM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define RPCM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/rpcm_pkg.sv =====
// Shared types, codes and helper functions for the retro pad mapper.
`default_nettype none
package rpcm_pkg;

   // Pad mode codes
   localparam logic [2:0] MODE_NES    = 3'd0;
   localparam logic [2:0] MODE_SNES   = 3'd1;
   localparam logic [2:0] MODE_NEOGEO = 3'd2;
   localparam logic [2:0] MODE_GC     = 3'd3;
   localparam logic [2:0] MODE_N64    = 3'd4;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_PAD_MODE    = 3'd0;
   localparam logic [2:0] REG_CAL_LEFT_X  = 3'd1;
   localparam logic [2:0] REG_CAL_LEFT_Y  = 3'd2;
   localparam logic [2:0] REG_CAL_RIGHT_X = 3'd3;
   localparam logic [2:0] REG_CAL_RIGHT_Y = 3'd4;
   localparam logic [2:0] REG_DEADZONE    = 3'd5;

   // Register reset values
   localparam logic [2:0] RST_PAD_MODE = MODE_NES;
   localparam logic [7:0] RST_CAL_LEFT  = 8'd128;
   localparam logic [7:0] RST_CAL_RIGHT = 8'd16;
   localparam logic [6:0] RST_DEADZONE  = 7'd10;

   // Button bit positions in the classic report
   localparam int BTN_W     = 15;
   localparam int BIT_LEFT  = 0;
   localparam int BIT_RIGHT = 1;
   localparam int BIT_UP    = 2;
   localparam int BIT_DOWN  = 3;
   localparam int BIT_A     = 4;
   localparam int BIT_B     = 5;
   localparam int BIT_X     = 6;
   localparam int BIT_Y     = 7;
   localparam int BIT_L     = 8;
   localparam int BIT_R     = 9;
   localparam int BIT_MINUS = 10;
   localparam int BIT_PLUS  = 11;
   localparam int BIT_HOME  = 12;
   localparam int BIT_ZL    = 13;
   localparam int BIT_ZR    = 14;

   // N64 C-button stick values and stick bit 7 flip
   localparam logic [7:0] C_LOW    = 8'd1;
   localparam logic [7:0] C_HIGH   = 8'd30;
   localparam logic [7:0] AXIS_FLIP = 8'h80;

   typedef struct packed {
      logic [2:0] pad_mode;
      logic [7:0] cal_left_x;
      logic [7:0] cal_left_y;
      logic [7:0] cal_right_x;
      logic [7:0] cal_right_y;
      logic [6:0] deadzone_radius;
   } cfg_type;

   typedef struct packed {
      logic [15:0] serial_word;
      logic [7:0]  report_byte0;
      logic [7:0]  report_byte1;
      logic [7:0]  report_byte2;
      logic [7:0]  report_byte3;
      logic [7:0]  report_byte4;
      logic [7:0]  report_byte5;
      logic [7:0]  report_byte6;
      logic [7:0]  report_byte7;
   } req_type;

   typedef struct packed {
      logic [BTN_W-1:0] button_bits;
      logic [7:0]       left_stick_x;
      logic [7:0]       left_stick_y;
      logic [7:0]       right_stick_x;
      logic [7:0]       right_stick_y;
      logic [7:0]       left_trigger;
      logic [7:0]       right_trigger;
   } rsp_type;

   // Report the calibration value when raw lies within radius of center
   function automatic logic [7:0] snap(input logic [7:0] raw, input logic [7:0] center,
                                       input logic [6:0] radius, input logic [7:0] cal);
      logic signed [8:0] diff;
      logic signed [8:0] rad;
      diff = signed'({1'b0, raw}) - signed'({1'b0, center});
      rad  = signed'({2'b00, radius});
      return ((diff >= -rad) && (diff <= rad)) ? cal : raw;
   endfunction

endpackage
`default_nettype wire

// ===== design/retro_pad_to_classic_mapper.sv =====
// Path: a request is accepted into the input register, then mapped into the result register.
// Throughput: one request per cycle while the result register is not held, set by the single mapping pass.
// Backpressure stalls the input register only when the result register is held.
// Reset (synchronous, active high) empties both registers, restores configuration defaults
// and clears the captured stick centers and L/Z swap.
`default_nettype none
`include "retro_pad_to_classic_mapper_assert.svh"
module retro_pad_to_classic_mapper (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_serial_word,
   input  wire logic [7:0]  req_report_byte0,
   input  wire logic [7:0]  req_report_byte1,
   input  wire logic [7:0]  req_report_byte2,
   input  wire logic [7:0]  req_report_byte3,
   input  wire logic [7:0]  req_report_byte4,
   input  wire logic [7:0]  req_report_byte5,
   input  wire logic [7:0]  req_report_byte6,
   input  wire logic [7:0]  req_report_byte7,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [14:0]      rsp_button_bits,
   output logic [7:0]       rsp_left_stick_x,
   output logic [7:0]       rsp_left_stick_y,
   output logic [7:0]       rsp_right_stick_x,
   output logic [7:0]       rsp_right_stick_y,
   output logic [7:0]       rsp_left_trigger,
   output logic [7:0]       rsp_right_trigger,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import rpcm_pkg::*;

   cfg_type cfg;
   req_type s1_data_ff;
   logic    s1_valid_ff;
   rsp_type map_rsp;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;
   logic    advance;
   logic    move;
   logic    accept;

   rpcm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rpcm_map u_map (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fire  (move),
      .req   (s1_data_ff),
      .rsp   (map_rsp)
   );

   // Handshake: result register frees when empty or taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign move      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // Hold the request in the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff.serial_word  <= req_serial_word;
         s1_data_ff.report_byte0 <= req_report_byte0;
         s1_data_ff.report_byte1 <= req_report_byte1;
         s1_data_ff.report_byte2 <= req_report_byte2;
         s1_data_ff.report_byte3 <= req_report_byte3;
         s1_data_ff.report_byte4 <= req_report_byte4;
         s1_data_ff.report_byte5 <= req_report_byte5;
         s1_data_ff.report_byte6 <= req_report_byte6;
         s1_data_ff.report_byte7 <= req_report_byte7;
      end
   end

   // Advance the mapped report into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_data_ff <= map_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_button_bits   = rsp_data_ff.button_bits;
   assign rsp_left_stick_x  = rsp_data_ff.left_stick_x;
   assign rsp_left_stick_y  = rsp_data_ff.left_stick_y;
   assign rsp_right_stick_x = rsp_data_ff.right_stick_x;
   assign rsp_right_stick_y = rsp_data_ff.right_stick_y;
   assign rsp_left_trigger  = rsp_data_ff.left_trigger;
   assign rsp_right_trigger = rsp_data_ff.right_trigger;

   // A stalled request stays in the input register untouched
   `RPCM_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_data_ff))
   // A request moved out of the input register shows up as a result
   `RPCM_ASSERT_NXT(a_move_to_rsp, clock, reset, move, rsp_valid_ff)
   // An accepted request always lands in the input register
   `RPCM_ASSERT_NXT(a_accept_lands, clock, reset, accept, s1_valid_ff)

endmodule
`default_nettype wire

// ===== design/rpcm_csr.sv =====
// APB-style configuration registers for the retro pad mapper.
`default_nettype none
module rpcm_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          psel,
   input  wire logic          penable,
   input  wire logic          pwrite,
   input  wire logic [4:0]    paddr,
   input  wire logic [31:0]   pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output rpcm_pkg::cfg_type  cfg
);
   import rpcm_pkg::*;

   cfg_type    cfg_ff;
   logic [2:0] index;
   logic       wr_en;

   assign index  = paddr[4:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pad_mode        <= RST_PAD_MODE;
         cfg_ff.cal_left_x      <= RST_CAL_LEFT;
         cfg_ff.cal_left_y      <= RST_CAL_LEFT;
         cfg_ff.cal_right_x     <= RST_CAL_RIGHT;
         cfg_ff.cal_right_y     <= RST_CAL_RIGHT;
         cfg_ff.deadzone_radius <= RST_DEADZONE;
      end else if (wr_en) begin
         unique case (index)
            REG_PAD_MODE:    cfg_ff.pad_mode        <= pwdata[2:0];
            REG_CAL_LEFT_X:  cfg_ff.cal_left_x      <= pwdata[7:0];
            REG_CAL_LEFT_Y:  cfg_ff.cal_left_y      <= pwdata[7:0];
            REG_CAL_RIGHT_X: cfg_ff.cal_right_x     <= pwdata[7:0];
            REG_CAL_RIGHT_Y: cfg_ff.cal_right_y     <= pwdata[7:0];
            REG_DEADZONE:    cfg_ff.deadzone_radius <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (index)
         REG_PAD_MODE:    prdata = {29'd0, cfg_ff.pad_mode};
         REG_CAL_LEFT_X:  prdata = {24'd0, cfg_ff.cal_left_x};
         REG_CAL_LEFT_Y:  prdata = {24'd0, cfg_ff.cal_left_y};
         REG_CAL_RIGHT_X: prdata = {24'd0, cfg_ff.cal_right_x};
         REG_CAL_RIGHT_Y: prdata = {24'd0, cfg_ff.cal_right_y};
         REG_DEADZONE:    prdata = {25'd0, cfg_ff.deadzone_radius};
         default:         prdata = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

// ===== design/rpcm_map.sv =====
// Button and stick mapping with stick center capture for the retro pad mapper.
`default_nettype none
module rpcm_map (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rpcm_pkg::cfg_type cfg,
   input  wire logic              fire,
   input  wire rpcm_pkg::req_type req,
   output rpcm_pkg::rsp_type      rsp
);
   import rpcm_pkg::*;

   logic       captured_ff;
   logic [7:0] neutral_lx_ff, neutral_ly_ff, neutral_rx_ff, neutral_ry_ff;
   logic       swap_ff;

   logic       cap_now;
   logic       is_n64;
   logic [7:0] new_lx, new_ly;
   logic       new_swap;
   logic [7:0] use_lx, use_ly, use_rx, use_ry;
   logic       use_swap;
   logic [6:0] rad_right;
   logic [15:0] w;
   logic [7:0] b0, b1;
   logic       lbit, zbit;

   assign w  = req.serial_word;
   assign b0 = req.report_byte0;
   assign b1 = req.report_byte1;

   // Pick centers: fresh capture on the first analog report, else the stored ones
   always_comb begin
      is_n64   = (cfg.pad_mode == MODE_N64);
      cap_now  = ((cfg.pad_mode == MODE_GC) || is_n64) && !captured_ff;
      new_lx   = is_n64 ? (req.report_byte2 ^ AXIS_FLIP) : req.report_byte2;
      new_ly   = is_n64 ? (req.report_byte3 ^ AXIS_FLIP) : req.report_byte3;
      new_swap = is_n64 && b1[5];
      use_lx   = cap_now ? new_lx : neutral_lx_ff;
      use_ly   = cap_now ? new_ly : neutral_ly_ff;
      use_rx   = cap_now ? req.report_byte4 : neutral_rx_ff;
      use_ry   = cap_now ? req.report_byte5 : neutral_ry_ff;
      use_swap = cap_now ? new_swap : swap_ff;
      rad_right = cfg.deadzone_radius >> 1;
      lbit     = use_swap ? b0[5] : b1[5];
      zbit     = use_swap ? b1[5] : b0[5];
   end

   // Map the report for the selected pad
   always_comb begin
      rsp.button_bits   = '0;
      rsp.left_stick_x  = cfg.cal_left_x;
      rsp.left_stick_y  = cfg.cal_left_y;
      rsp.right_stick_x = cfg.cal_right_x;
      rsp.right_stick_y = cfg.cal_right_y;
      rsp.left_trigger  = 8'd0;
      rsp.right_trigger = 8'd0;
      case (cfg.pad_mode)
         MODE_NES: begin
            rsp.button_bits[BIT_LEFT]  = w[6];
            rsp.button_bits[BIT_RIGHT] = w[7];
            rsp.button_bits[BIT_UP]    = w[4];
            rsp.button_bits[BIT_DOWN]  = w[5];
            rsp.button_bits[BIT_A]     = w[0];
            rsp.button_bits[BIT_B]     = w[1];
            rsp.button_bits[BIT_MINUS] = w[2];
            rsp.button_bits[BIT_PLUS]  = w[3];
            rsp.button_bits[BIT_HOME]  = w[2] && w[3];
         end
         MODE_SNES: begin
            rsp.button_bits[BIT_LEFT]  = w[6];
            rsp.button_bits[BIT_RIGHT] = w[7];
            rsp.button_bits[BIT_UP]    = w[4];
            rsp.button_bits[BIT_DOWN]  = w[5];
            rsp.button_bits[BIT_B]     = w[0];
            rsp.button_bits[BIT_Y]     = w[1];
            rsp.button_bits[BIT_MINUS] = w[2];
            rsp.button_bits[BIT_PLUS]  = w[3];
            rsp.button_bits[BIT_A]     = w[8];
            rsp.button_bits[BIT_X]     = w[9];
            rsp.button_bits[BIT_L]     = w[10];
            rsp.button_bits[BIT_R]     = w[11];
            rsp.button_bits[BIT_HOME]  = w[2] && w[3];
         end
         MODE_NEOGEO: begin
            rsp.button_bits[BIT_LEFT]  = w[1];
            rsp.button_bits[BIT_RIGHT] = w[11];
            rsp.button_bits[BIT_UP]    = w[2];
            rsp.button_bits[BIT_DOWN]  = w[12];
            rsp.button_bits[BIT_B]     = w[0];
            rsp.button_bits[BIT_Y]     = w[15];
            rsp.button_bits[BIT_MINUS] = w[8];
            rsp.button_bits[BIT_PLUS]  = w[14];
            rsp.button_bits[BIT_A]     = w[10];
            rsp.button_bits[BIT_X]     = w[9];
            rsp.button_bits[BIT_HOME]  = w[8] && w[14];
         end
         MODE_GC: begin
            rsp.button_bits[BIT_LEFT]  = b1[0];
            rsp.button_bits[BIT_RIGHT] = b1[1];
            rsp.button_bits[BIT_UP]    = b1[3];
            rsp.button_bits[BIT_DOWN]  = b1[2];
            rsp.button_bits[BIT_Y]     = b0[3];
            rsp.button_bits[BIT_B]     = b0[1];
            rsp.button_bits[BIT_X]     = b0[2];
            rsp.button_bits[BIT_A]     = b0[0];
            rsp.button_bits[BIT_PLUS]  = b0[4];
            rsp.button_bits[BIT_L]     = b1[6];
            rsp.button_bits[BIT_R]     = b1[5];
            rsp.button_bits[BIT_ZL]    = b1[4];
            rsp.button_bits[BIT_ZR]    = b1[4];
            rsp.button_bits[BIT_HOME]  = b1[3] && b0[4];
            rsp.left_stick_x  = snap(req.report_byte2, use_lx, cfg.deadzone_radius,
                                     cfg.cal_left_x);
            rsp.left_stick_y  = snap(req.report_byte3, use_ly, cfg.deadzone_radius,
                                     cfg.cal_left_y);
            rsp.right_stick_x = snap(req.report_byte4, use_rx, rad_right, cfg.cal_right_x);
            rsp.right_stick_y = snap(req.report_byte5, use_ry, rad_right, cfg.cal_right_y);
            rsp.left_trigger  = req.report_byte6;
            rsp.right_trigger = req.report_byte7;
         end
         MODE_N64: begin
            rsp.button_bits[BIT_LEFT]  = b0[1];
            rsp.button_bits[BIT_RIGHT] = b0[0];
            rsp.button_bits[BIT_UP]    = b0[3];
            rsp.button_bits[BIT_DOWN]  = b0[2];
            rsp.button_bits[BIT_B]     = b0[6];
            rsp.button_bits[BIT_A]     = b0[7];
            rsp.button_bits[BIT_PLUS]  = b0[4];
            rsp.button_bits[BIT_R]     = b1[4];
            rsp.button_bits[BIT_L]     = lbit;
            rsp.button_bits[BIT_ZL]    = zbit;
            rsp.button_bits[BIT_ZR]    = zbit;
            rsp.button_bits[BIT_Y]     = b1[1];
            rsp.button_bits[BIT_X]     = b1[0];
            rsp.button_bits[BIT_HOME]  = b0[3] && b0[4];
            // C-buttons drive the right stick
            if (b1[3]) begin
               rsp.right_stick_y = C_HIGH;
            end else if (b1[2]) begin
               rsp.right_stick_y = C_LOW;
            end
            if (b1[1]) begin
               rsp.right_stick_x = C_LOW;
            end else if (b1[0]) begin
               rsp.right_stick_x = C_HIGH;
            end
            rsp.left_stick_x = snap(req.report_byte2 ^ AXIS_FLIP, use_lx,
                                    cfg.deadzone_radius, cfg.cal_left_x);
            rsp.left_stick_y = snap(req.report_byte3 ^ AXIS_FLIP, use_ly,
                                    cfg.deadzone_radius, cfg.cal_left_y);
         end
         default: ;
      endcase
   end

   // Latch the stick centers once, on the first analog report
   always_ff @(posedge clock) begin
      if (reset) begin
         captured_ff   <= 1'b0;
         neutral_lx_ff <= 8'd0;
         neutral_ly_ff <= 8'd0;
         neutral_rx_ff <= 8'd0;
         neutral_ry_ff <= 8'd0;
         swap_ff       <= 1'b0;
      end else if (fire && cap_now) begin
         captured_ff   <= 1'b1;
         neutral_lx_ff <= new_lx;
         neutral_ly_ff <= new_ly;
         neutral_rx_ff <= req.report_byte4;
         neutral_ry_ff <= req.report_byte5;
         swap_ff       <= new_swap;
      end
   end

endmodule
`default_nettype wire
